// File: hw/rtl/pgli_pkg.sv
// Shared types, widths and helpers for the pitch gap log interpolator.
// No dependencies; used by every module of the block.
package pgli_pkg;

    localparam int PITCH_W         = 16;
    localparam int CNT_W           = 6;
    localparam int LOG_W           = 16;
    localparam int EXP_W           = 4;
    localparam int FRAC_W          = 12;
    localparam int PROD_W          = 22;
    localparam int NUM_W           = 23;
    localparam int DEN_W           = 7;
    localparam int GAP_LIMIT_DEF   = 63;
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic                 is_voiced;
        logic [PITCH_W-1:0]   pitch;
        logic [PITCH_W-1:0]   prev;
        logic                 have_prev;
        logic [CNT_W-1:0]     cnt;
        logic                 ovf;
        logic                 fin;
    } pgli_cmd_t;

    function automatic logic [EXP_W-1:0] lead_one(input logic [PITCH_W-1:0] x);
        logic [EXP_W-1:0] e;
        e = '0;
        for (int i = 0; i < PITCH_W; i++) begin
            if (x[i]) begin
                e = EXP_W'(i);
            end
        end
        return e;
    endfunction

endpackage

// File: hw/rtl/pgli_fifo.sv
// Small flip-flop queue of gap commands between front and back.
// Depends on pgli_pkg for the command type.
module pgli_fifo #(
    parameter int DEPTH = pgli_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  pgli_pkg::pgli_cmd_t push_data,
    output logic                full,
    input  logic                pop,
    output pgli_pkg::pgli_cmd_t pop_data,
    output logic                empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pgli_pkg::pgli_cmd_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/pgli_front.sv
// Input side: classifies frames, tracks the gap and issues commands.
// Depends on pgli_pkg.
module pgli_front #(
    parameter int GAP_LIMIT = pgli_pkg::GAP_LIMIT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,
    input  logic                s_tuser,
    input  logic                s_tlast,
    output logic                push,
    output pgli_pkg::pgli_cmd_t cmd,
    input  logic                full
);
    localparam int CW = pgli_pkg::CNT_W;

    logic                          mask_en_reg;
    logic [pgli_pkg::PITCH_W-1:0]  prev_reg, prev_next;
    logic                          have_prev_reg, have_prev_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic                          accept, voiced, flush, ovf;
    logic [CW:0]                   cnt_inc;

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;
    assign voiced   = (s_tdata != '0) && (!mask_en_reg || s_tuser);
    assign cnt_inc  = {1'b0, cnt_reg} + 1'b1;
    assign ovf      = (cnt_inc >= (CW + 1)'(GAP_LIMIT));
    assign flush    = ovf || s_tlast;

    always_comb begin
        cmd.is_voiced = voiced;
        cmd.pitch     = voiced ? s_tdata : (have_prev_reg ? prev_reg : '0);
        cmd.prev      = prev_reg;
        cmd.have_prev = have_prev_reg;
        cmd.cnt       = voiced ? cnt_reg : cnt_inc[CW-1:0];
        cmd.ovf       = voiced ? 1'b0 : ovf;
        cmd.fin       = s_tlast;
        push          = accept && (voiced || flush);

        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        cnt_next       = cnt_reg;
        if (accept) begin
            if (voiced) begin
                prev_next      = s_tdata;
                have_prev_next = 1'b1;
                cnt_next       = '0;
            end else begin
                cnt_next = flush ? '0 : cnt_inc[CW-1:0];
            end
            if (s_tlast) begin
                prev_next      = '0;
                have_prev_next = 1'b0;
                cnt_next       = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_en_reg   <= 1'b1;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                mask_en_reg <= cfg_wr_data;
            end
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            cnt_reg       <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/pgli_logfrac.sv
// Iterative log2 fraction unit: one squaring step per cycle, one fraction bit per step.
// Depends on pgli_pkg.
module pgli_logfrac (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [15:0]                   mant,
    output logic                          done,
    output logic [pgli_pkg::FRAC_W-1:0]   frac
);
    localparam int FW = pgli_pkg::FRAC_W;
    localparam int SW = $clog2(FW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW-1:0] step_reg, step_next;
    logic [15:0]   y_reg, y_next;
    logic [FW-1:0] f_reg, f_next;
    logic [31:0]   sq;
    logic [16:0]   t;

    assign sq   = y_reg * y_reg;
    assign t    = sq[31:15];
    assign done = done_reg;
    assign frac = f_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        y_next    = y_reg;
        f_next    = f_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            y_next    = mant;
            f_next    = '0;
        end else if (busy_reg) begin
            y_next    = t[16] ? t[16:1] : t[15:0];
            f_next    = {f_reg[FW-2:0], t[16]};
            step_next = step_reg + 1'b1;
            if (step_reg == SW'(FW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        y_reg    <= y_next;
        f_reg    <= f_next;
    end

endmodule

// File: hw/rtl/pgli_back.sv
// Result side: expands commands into frames, interpolating in the log domain.
// Depends on pgli_pkg and pgli_logfrac.
module pgli_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  pgli_pkg::pgli_cmd_t q_data,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);
    localparam int CW  = pgli_pkg::CNT_W;
    localparam int LW  = pgli_pkg::LOG_W;
    localparam int EW  = pgli_pkg::EXP_W;
    localparam int FW  = pgli_pkg::FRAC_W;
    localparam int PW  = pgli_pkg::PROD_W;
    localparam int NW  = pgli_pkg::NUM_W;
    localparam int DW  = pgli_pkg::DEN_W;
    localparam int DCW = $clog2(NW + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_NEXT, S_LOGA, S_LOGB, S_MUL, S_DIV, S_BLEND, S_SRCH, S_WAIT, S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    pgli_pkg::pgli_cmd_t cmd_reg, cmd_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [EW-1:0]       ea_reg, ea_next, eb_reg, eb_next;
    logic [LW-1:0]       la_reg, la_next, lb_reg, lb_next, l_reg, l_next;
    logic                neg_reg, neg_next;
    logic [NW-1:0]       dvd_reg, dvd_next;
    logic [DW-1:0]       rem_reg, rem_next;
    logic [DCW-1:0]      dstep_reg, dstep_next;
    logic [15:0]         lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [15:0]         val_reg, val_next;
    logic                fill_reg, fill_next, ovf_reg, ovf_next;
    logic                last_reg, last_next, end_reg, end_next;
    logic                m_valid_reg, m_valid_next;
    logic [15:0]         m_data_reg, m_data_next;
    logic [1:0]          m_user_reg, m_user_next;
    logic                m_last_reg, m_last_next;

    logic                lf_start, lf_done;
    logic [15:0]         lf_mant;
    logic [FW-1:0]       lf_frac;
    logic [DW-1:0]       den;
    logic [DW:0]         dsr, trial;
    logic [LW-1:0]       mag;
    logic [PW-1:0]       prod;
    logic [NW+1:0]       li;
    logic [16:0]         mid_sum, rnd_sum;
    logic [EW-1:0]       sh, e_tmp;

    pgli_logfrac u_logfrac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lf_start),
        .mant    (lf_mant),
        .done    (lf_done),
        .frac    (lf_frac)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    assign den     = {1'b0, cmd_reg.cnt} + 1'b1;
    assign dsr     = {den, 1'b0};
    assign trial   = {rem_reg, dvd_reg[NW-1]};
    assign mag     = (lb_reg >= la_reg) ? lb_reg - la_reg : la_reg - lb_reg;
    assign prod    = PW'(mag) * PW'(k_reg);
    assign li      = neg_reg ? (NW + 2)'(la_reg) - (NW + 2)'(dvd_reg)
                             : (NW + 2)'(la_reg) + (NW + 2)'(dvd_reg);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + 1'b1;
    assign sh      = EW'(15) - l_reg[LW-1:FW];
    assign rnd_sum = {1'b0, lo_reg} + ((17'd1 << sh) >> 1);

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        k_next       = k_reg;
        ea_next      = ea_reg;
        eb_next      = eb_reg;
        la_next      = la_reg;
        lb_next      = lb_reg;
        l_next       = l_reg;
        neg_next     = neg_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        dstep_next   = dstep_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        val_next     = val_reg;
        fill_next    = fill_reg;
        ovf_next     = ovf_reg;
        last_next    = last_reg;
        end_next     = end_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        q_pop        = 1'b0;
        lf_start     = 1'b0;
        lf_mant      = '0;
        e_tmp        = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    k_next     = CW'(1);
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                if (k_reg <= cmd_reg.cnt && cmd_reg.cnt != '0) begin
                    fill_next = 1'b1;
                    ovf_next  = cmd_reg.ovf;
                    last_next = !cmd_reg.is_voiced && (k_reg == cmd_reg.cnt);
                    end_next  = !cmd_reg.is_voiced && (k_reg == cmd_reg.cnt) && cmd_reg.fin;
                    if (cmd_reg.is_voiced && cmd_reg.have_prev) begin
                        if (k_reg == CW'(1)) begin
                            e_tmp      = pgli_pkg::lead_one(cmd_reg.prev);
                            ea_next    = e_tmp;
                            lf_start   = 1'b1;
                            lf_mant    = cmd_reg.prev << (EW'(15) - e_tmp);
                            state_next = S_LOGA;
                        end else begin
                            state_next = S_MUL;
                        end
                    end else begin
                        val_next   = cmd_reg.pitch;
                        state_next = S_EMIT;
                    end
                end else begin
                    val_next   = cmd_reg.pitch;
                    fill_next  = 1'b0;
                    ovf_next   = 1'b0;
                    last_next  = 1'b1;
                    end_next   = cmd_reg.fin;
                    state_next = S_EMIT;
                end
            end
            S_LOGA: begin
                if (lf_done) begin
                    la_next    = (cmd_reg.prev == '0) ? '0 : {ea_reg, lf_frac};
                    e_tmp      = pgli_pkg::lead_one(cmd_reg.pitch);
                    eb_next    = e_tmp;
                    lf_start   = 1'b1;
                    lf_mant    = cmd_reg.pitch << (EW'(15) - e_tmp);
                    state_next = S_LOGB;
                end
            end
            S_LOGB: begin
                if (lf_done) begin
                    lb_next    = (cmd_reg.pitch == '0) ? '0 : {eb_reg, lf_frac};
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                neg_next   = (lb_reg < la_reg);
                dvd_next   = {prod, 1'b0} + NW'(den);
                rem_next   = '0;
                dstep_next = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (trial >= dsr) begin
                    rem_next = DW'(trial - dsr);
                    dvd_next = {dvd_reg[NW-2:0], 1'b1};
                end else begin
                    rem_next = trial[DW-1:0];
                    dvd_next = {dvd_reg[NW-2:0], 1'b0};
                end
                dstep_next = dstep_reg + 1'b1;
                if (dstep_reg == DCW'(NW - 1)) begin
                    state_next = S_BLEND;
                end
            end
            S_BLEND: begin
                if (li[NW+1]) begin
                    l_next = '0;
                end else if (li[NW:LW] != '0) begin
                    l_next = '1;
                end else begin
                    l_next = li[LW-1:0];
                end
                lo_next    = 16'h8000;
                hi_next    = 16'hFFFF;
                state_next = S_SRCH;
            end
            S_SRCH: begin
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_sum[16:1];
                    lf_start   = 1'b1;
                    lf_mant    = mid_sum[16:1];
                    state_next = S_WAIT;
                end else begin
                    val_next   = (sh == '0) ? lo_reg : 16'(rnd_sum >> sh);
                    state_next = S_EMIT;
                end
            end
            S_WAIT: begin
                if (lf_done) begin
                    if (lf_frac <= l_reg[FW-1:0]) begin
                        lo_next = mid_reg;
                    end else begin
                        hi_next = mid_reg - 1'b1;
                    end
                    state_next = S_SRCH;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = val_reg;
                    m_user_next  = {ovf_reg, fill_reg};
                    m_last_next  = end_reg;
                    if (last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_NEXT;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg    <= cmd_next;
        k_reg      <= k_next;
        ea_reg     <= ea_next;
        eb_reg     <= eb_next;
        la_reg     <= la_next;
        lb_reg     <= lb_next;
        l_reg      <= l_next;
        neg_reg    <= neg_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        dstep_reg  <= dstep_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        val_reg    <= val_next;
        fill_reg   <= fill_next;
        ovf_reg    <= ovf_next;
        last_reg   <= last_next;
        end_reg    <= end_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

endmodule

// File: hw/rtl/pitch_gap_log_interpolator_unit.sv
// Pitch gap filler top level: front classifier, command queue, fill engine.
// Depends on pgli_pkg, pgli_front, pgli_fifo, pgli_back.
//
// Takes Q12.4 pitch frames and returns one dense frame per input frame, unvoiced
// runs filled by log-domain interpolation between voiced neighbors or held at an
// edge. Input frames are accepted whenever the command queue has room.
// Output: a passed voiced frame or held frame needs no arithmetic; each
// interpolated frame takes a divide and a 15-step search of the shared log2
// fraction unit, plus the two endpoint logs once per gap. The shared log2
// unit sets the fill rate.
module pitch_gap_log_interpolator_unit #(
    parameter int GAP_LIMIT   = pgli_pkg::GAP_LIMIT_DEF,
    parameter int QUEUE_DEPTH = pgli_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,  // use_voicing_mask
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // pitch_hz
    input  logic        s_tuser,      // mask_bit
    input  logic        s_tlast,      // final_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // dense_pitch
    output logic [1:0]  m_tuser,      // [1] gap_overflow, [0] was_filled
    output logic        m_tlast       // end_of_curve
);
    pgli_pkg::pgli_cmd_t push_cmd, pop_cmd;
    logic push, full, pop, empty;

    pgli_front #(
        .GAP_LIMIT (GAP_LIMIT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .push        (push),
        .cmd         (push_cmd),
        .full        (full)
    );

    pgli_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .empty     (empty)
    );

    pgli_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_data   (pop_cmd),
        .q_empty  (empty),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
